FILE: rtl/dmet_pkg.sv
// shared constants, types and character codes for the decimal-to-text formatter
// no dependencies; imported by every module of the block
package dmet_pkg;

	// mantissa width used by the conversion; the input port stays 64 bits
	localparam int MANTISSA_BITS = 64;
	localparam int MANT_IN_W = 64;
	localparam int EXP_W = 32;
	localparam int CHAR_W = 7;
	localparam int EX_W = 5;

	// shift length of the double-dabble loop covers both the mantissa and the exponent
	localparam int CONV_BITS = (MANTISSA_BITS > EXP_W) ? MANTISSA_BITS : EXP_W;

	// decimal digit counts of the two magnitudes
	localparam int MDIG = (MANTISSA_BITS * 30103) / 100000 + 1;
	localparam int EDIG = 10;
	localparam int CNT_W = $clog2(((MDIG > EDIG) ? MDIG : EDIG) + 1);
	localparam int MP_W = $clog2(MDIG);
	localparam int EP_W = $clog2(EDIG);

	// exponent window for fixed notation
	localparam int FIX_EXP_HIGH = 6;
	localparam int FIX_EXP_LOW = -9;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_E = 7'h65;

	// one classified number, as held in the queue
	typedef struct packed {
		logic                     neg;
		logic [MANTISSA_BITS-1:0] mag;
		logic                     fixed;
		logic signed [EX_W-1:0]   ex;
		logic                     eneg;
		logic [EXP_W-1:0]         emag;
	} item_t;

	// back end status seen by the top level
	typedef struct packed {
		logic busy;
		logic emitting;
	} back_status_t;

endpackage

FILE: rtl/dmet_front.sv
// front end: splits sign and magnitude of mantissa and exponent, picks the notation
// depends on dmet_pkg
module dmet_front (
	input  logic signed [dmet_pkg::MANT_IN_W-1:0] mantissa,
	input  logic signed [dmet_pkg::EXP_W-1:0]     exponent,
	output dmet_pkg::item_t                       item
);
	import dmet_pkg::*;

	logic [MANTISSA_BITS-1:0] m;
	logic [EXP_W-1:0]         e_raw;

	assign m = mantissa[MANTISSA_BITS-1:0];
	assign e_raw = exponent;

	// mantissa sign and magnitude; the most negative value stays as unsigned
	assign item.neg = m[MANTISSA_BITS-1];
	assign item.mag = m[MANTISSA_BITS-1] ? (~m + 1'b1) : m;

	// fixed notation only inside the exponent window
	assign item.fixed = (exponent <= FIX_EXP_HIGH) && (exponent >= FIX_EXP_LOW);
	assign item.ex = exponent[EX_W-1:0];

	// exponent sign and magnitude
	assign item.eneg = e_raw[EXP_W-1];
	assign item.emag = e_raw[EXP_W-1] ? (~e_raw + 32'd1) : e_raw;

endmodule

FILE: rtl/dmet_queue.sv
// two-entry queue of classified numbers between front and back end
// depends on dmet_pkg
module dmet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  dmet_pkg::item_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output dmet_pkg::item_t rd_data
);
	import dmet_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QP_W = $clog2(QDEPTH);

	item_t             mem_q [QDEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QP_W:0]     count_q;
	logic              do_wr;
	logic              do_rd;

	assign full = (count_q == (QP_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dmet_back.sv
// back end: double-dabble conversion, text layout and one character per transaction
// depends on dmet_pkg
module dmet_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  dmet_pkg::item_t              q_data,
	output logic                         q_take,
	input  logic                         pop,
	output logic                         empty,
	output logic [dmet_pkg::CHAR_W-1:0]  out_char,
	output logic                         last,
	output dmet_pkg::back_status_t       status
);
	import dmet_pkg::*;

	localparam int NPH = 10;
	localparam int IT_W = $clog2(CONV_BITS);
	localparam int SW = CNT_W + 2;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CONV,
		B_COUNT,
		B_LEN,
		B_START,
		B_EMIT
	} bstate_t;

	typedef enum logic [3:0] {
		PH_SIGN,
		PH_INT,
		PH_IZERO,
		PH_LZERO,
		PH_POINT,
		PH_FZERO,
		PH_FRAC,
		PH_E,
		PH_ESIGN,
		PH_EDIG
	} phase_t;

	bstate_t                state_q;
	phase_t                 phase_q;
	item_t                  item_q;
	logic [CONV_BITS-1:0]   mshift_q;
	logic [CONV_BITS-1:0]   eshift_q;
	logic [MDIG*4-1:0]      mbcd_q;
	logic [EDIG*4-1:0]      ebcd_q;
	logic [IT_W-1:0]        iter_q;
	logic [CNT_W-1:0]       nd_q;
	logic [CNT_W-1:0]       ne_q;
	logic [MP_W-1:0]        mp_q;
	logic [EP_W-1:0]        ep_q;
	logic [CNT_W-1:0]       len_q [NPH];
	logic [CNT_W-1:0]       rem_q;
	logic                   ovalid_q;
	logic [CHAR_W-1:0]      ochar_q;
	logic                   olast_q;

	logic [MDIG*4-1:0]      mbcd_nxt;
	logic [EDIG*4-1:0]      ebcd_nxt;
	logic [CNT_W-1:0]       nd_c;
	logic [CNT_W-1:0]       ne_c;
	logic [CNT_W-1:0]       nd_m1;
	logic [CNT_W-1:0]       ne_m1;
	logic [CNT_W-1:0]       len_c [NPH];
	phase_t                 nxt_ph;
	logic                   nxt_any;
	logic [CHAR_W-1:0]      char_c;
	logic                   last_c;
	logic                   adv;

	assign q_take = (state_q == B_IDLE) && q_valid;
	assign empty = !ovalid_q;
	assign out_char = ochar_q;
	assign last = olast_q;
	assign status.busy = (state_q != B_IDLE);
	assign status.emitting = (state_q == B_EMIT);
	assign adv = !ovalid_q || pop;

	// add-3 correction on every digit, then shift in the next binary bit
	always_comb begin
		logic [MDIG*4-1:0] madj;
		logic [EDIG*4-1:0] eadj;
		logic [3:0]        md;
		logic [3:0]        ed;
		for (int i = 0; i < MDIG; i++) begin
			md = mbcd_q[i*4 +: 4];
			madj[i*4 +: 4] = (md >= 4'd5) ? (md + 4'd3) : md;
		end
		for (int i = 0; i < EDIG; i++) begin
			ed = ebcd_q[i*4 +: 4];
			eadj[i*4 +: 4] = (ed >= 4'd5) ? (ed + 4'd3) : ed;
		end
		mbcd_nxt = {madj[MDIG*4-2:0], mshift_q[CONV_BITS-1]};
		ebcd_nxt = {eadj[EDIG*4-2:0], eshift_q[CONV_BITS-1]};
	end

	// significant digit counts, at least one digit
	always_comb begin
		nd_c = CNT_W'(1);
		ne_c = CNT_W'(1);
		for (int i = 0; i < MDIG; i++) begin
			if (mbcd_q[i*4 +: 4] != 4'd0) begin
				nd_c = CNT_W'(i + 1);
			end
		end
		for (int i = 0; i < EDIG; i++) begin
			if (ebcd_q[i*4 +: 4] != 4'd0) begin
				ne_c = CNT_W'(i + 1);
			end
		end
	end

	assign nd_m1 = nd_q - CNT_W'(1);
	assign ne_m1 = ne_q - CNT_W'(1);

	// character count of each section of the text
	always_comb begin
		logic signed [SW-1:0] exs;
		logic signed [SW-1:0] ndi;
		logic signed [SW-1:0] idr;
		logic signed [SW-1:0] idg;
		logic signed [SW-1:0] izr;
		logic signed [SW-1:0] fzr;
		logic signed [SW-1:0] fzg;
		logic signed [SW-1:0] frc;
		logic                 lzero;
		exs = {{(SW-EX_W){item_q.ex[EX_W-1]}}, item_q.ex};
		ndi = {2'b00, nd_q};
		idr = exs[SW-1] ? (ndi + exs) : ndi;
		idg = idr[SW-1] ? '0 : idr;
		izr = exs[SW-1] ? '0 : exs;
		lzero = (ndi <= -exs);
		fzr = -exs - ndi;
		fzg = fzr[SW-1] ? '0 : fzr;
		frc = ndi - idg;
		for (int i = 0; i < NPH; i++) begin
			len_c[i] = '0;
		end
		len_c[PH_SIGN] = {{(CNT_W-1){1'b0}}, item_q.neg};
		if (item_q.fixed) begin
			len_c[PH_INT] = idg[CNT_W-1:0];
			len_c[PH_IZERO] = izr[CNT_W-1:0];
			len_c[PH_LZERO] = {{(CNT_W-1){1'b0}}, lzero};
			len_c[PH_POINT] = CNT_W'(1);
			len_c[PH_FZERO] = fzg[CNT_W-1:0];
			len_c[PH_FRAC] = frc[CNT_W-1:0];
		end else begin
			len_c[PH_INT] = nd_q;
			len_c[PH_E] = CNT_W'(1);
			len_c[PH_ESIGN] = {{(CNT_W-1){1'b0}}, item_q.eneg};
			len_c[PH_EDIG] = ne_q;
		end
	end

	// next non-empty section, from the first one when starting
	always_comb begin
		nxt_ph = PH_SIGN;
		nxt_any = 1'b0;
		for (int i = NPH - 1; i >= 0; i--) begin
			if (((i > int'(phase_q)) || (state_q == B_START)) && (len_q[i] != '0)) begin
				nxt_ph = phase_t'(i);
				nxt_any = 1'b1;
			end
		end
	end

	// character of the current section
	always_comb begin
		case (phase_q)
			PH_SIGN: begin
				char_c = CH_MINUS;
			end
			PH_INT, PH_FRAC: begin
				char_c = CH_ZERO | {3'b000, mbcd_q[{mp_q, 2'b00} +: 4]};
			end
			PH_IZERO, PH_LZERO, PH_FZERO: begin
				char_c = CH_ZERO;
			end
			PH_POINT: begin
				char_c = CH_POINT;
			end
			PH_E: begin
				char_c = CH_E;
			end
			PH_ESIGN: begin
				char_c = CH_MINUS;
			end
			PH_EDIG: begin
				char_c = CH_ZERO | {3'b000, ebcd_q[{ep_q, 2'b00} +: 4]};
			end
			default: begin
				char_c = CH_ZERO;
			end
		endcase
	end

	assign last_c = (rem_q == CNT_W'(1)) && !nxt_any;

	// payload registers of the conversion
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					item_q <= q_data;
					mshift_q <= CONV_BITS'(q_data.mag);
					eshift_q <= CONV_BITS'(q_data.emag);
					mbcd_q <= '0;
					ebcd_q <= '0;
				end
			end
			B_CONV: begin
				mshift_q <= {mshift_q[CONV_BITS-2:0], 1'b0};
				eshift_q <= {eshift_q[CONV_BITS-2:0], 1'b0};
				mbcd_q <= mbcd_nxt;
				ebcd_q <= ebcd_nxt;
			end
			B_COUNT: begin
				nd_q <= nd_c;
				ne_q <= ne_c;
			end
			B_LEN: begin
				len_q <= len_c;
			end
			default: begin
			end
		endcase
	end

	// sequencer, digit pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			phase_q <= PH_SIGN;
			iter_q <= '0;
			ovalid_q <= 1'b0;
			ochar_q <= '0;
			olast_q <= 1'b0;
			rem_q <= '0;
			mp_q <= '0;
			ep_q <= '0;
		end else begin
			// while emitting, the output register is refilled below instead
			if (pop && ovalid_q && (state_q != B_EMIT)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						iter_q <= '0;
						state_q <= B_CONV;
					end
				end
				B_CONV: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == IT_W'(CONV_BITS - 1)) begin
						state_q <= B_COUNT;
					end
				end
				B_COUNT: begin
					state_q <= B_LEN;
				end
				B_LEN: begin
					mp_q <= nd_m1[MP_W-1:0];
					ep_q <= ne_m1[EP_W-1:0];
					state_q <= B_START;
				end
				B_START: begin
					phase_q <= nxt_ph;
					rem_q <= len_q[nxt_ph];
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (adv) begin
						ovalid_q <= 1'b1;
						ochar_q <= char_c;
						olast_q <= last_c;
						if ((phase_q == PH_INT) || (phase_q == PH_FRAC)) begin
							mp_q <= mp_q - 1'b1;
						end
						if (phase_q == PH_EDIG) begin
							ep_q <= ep_q - 1'b1;
						end
						if (rem_q == CNT_W'(1)) begin
							if (nxt_any) begin
								phase_q <= nxt_ph;
								rem_q <= len_q[nxt_ph];
							end else begin
								state_q <= B_IDLE;
							end
						end else begin
							rem_q <= rem_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/decimal_mantissa_exponent_to_text_unit.sv
// top level of the decimal mantissa/exponent to ascii text formatter
// depends on dmet_pkg, dmet_front, dmet_queue, dmet_back
//
// channel   direction  handshake          payload
// input     in         push / full        mantissa[63:0] signed, exponent[31:0] signed
// result    out        empty / pop        out_char[6:0], last
//
// per number the back end takes it from the queue, runs 64 double-dabble shift steps,
// counts the digits and lays out the text, then emits one character per cycle while
// pop keeps the output free, through a single output register
// the front takes a new number every cycle until the two-entry queue fills
// reset clears the queue pointers, the sequencer and the output register
// pop held low stalls emission with the pending character held on the result ports
module decimal_mantissa_exponent_to_text_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [dmet_pkg::MANT_IN_W-1:0]  mantissa,
	input  logic signed [dmet_pkg::EXP_W-1:0]      exponent,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [dmet_pkg::CHAR_W-1:0]            out_char,
	output logic                                   last
);
	import dmet_pkg::*;

	item_t        front_item;
	item_t        q_data;
	logic         q_valid;
	logic         q_take;
	back_status_t st;

	// classify the incoming number
	dmet_front u_front (
		.mantissa (mantissa),
		.exponent (exponent),
		.item     (front_item)
	);

	// decouple front and back end
	dmet_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (front_item),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	// convert and emit
	dmet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_take   (q_take),
		.pop      (pop),
		.empty    (empty),
		.out_char (out_char),
		.last     (last),
		.status   (st)
	);

`ifndef ASSERT_OFF
	// an accepted number is waiting in the queue the next cycle
	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> q_valid)
		else $error("accepted number missing from queue");

	// an idle back end picks up a waiting number at once
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !st.busy) |=> st.busy)
		else $error("waiting number not taken by idle back end");

	// outside emission a waiting character ends its number
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!st.emitting && !empty) |-> last)
		else $error("unfinished text left while back end not emitting");

	// no bubble inside the text of one number
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> !empty)
		else $error("gap in character transactions of one number");
`endif

endmodule

FILE: test/decimal_mantissa_exponent_to_text_unit_test.sv
// testbench for the decimal mantissa/exponent to ascii text formatter
// drives numbers through the push/full queue, checks every character against given text or a local predictor
// depends on dmet_pkg and decimal_mantissa_exponent_to_text_unit
`timescale 1ns / 1ps

module decimal_mantissa_exponent_to_text_unit_test;
	import dmet_pkg::*;

	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM = 445;
	localparam int MAX_TEXT = 32;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 600;
	localparam int PAUSE_AT = 300;
	localparam int QUIET_FROM = 380;
	localparam int QUIET_TO = 430;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS = 20;
	localparam int TIMEOUT_NS = 6_000_000;

	// one expected character of the text
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        push = 1'b0;
	logic                        full;
	logic signed [MANT_IN_W-1:0] mantissa = '0;
	logic signed [EXP_W-1:0]     exponent = '0;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [CHAR_W-1:0]           out_char;
	logic                        last;

	text_char_t expected_chars[$];
	string      drive_text = "";
	int         error_count = 0;
	int         accepted_count = 0;
	int         checked_chars = 0;
	int         fixed_count = 0;
	int         sci_count = 0;
	int         stall_cycles = 0;
	bit         held_off = 1'b0;

	// directed numbers; text is given where it is obvious, empty means use the predictor
	logic [MANT_IN_W-1:0] dir_mant [N_DIRECTED] = '{
		64'd0, 64'd0, 64'd0, 64'd0, 64'd5, 64'd5, 64'd100, 64'd12345, -64'sd12345,
		64'd1, 64'd1, 64'd1, 64'd1, -64'sd1, -64'sd1, 64'd123456789, 64'd1234567890,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'h8000_0000_0000_0000, -64'sd7, 64'h8000_0000_0000_0000,
		64'h7FFF_FFFF_FFFF_FFFF, -64'sd42
	};
	logic [EXP_W-1:0] dir_expo [N_DIRECTED] = '{
		32'd0, -32'sd2, -32'sd9, 32'd7, 32'd2, -32'sd3, -32'sd2, -32'sd2, -32'sd7,
		32'd6, 32'd7, -32'sd9, -32'sd10, -32'sd9, 32'd0, -32'sd9, -32'sd9,
		32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd6,
		-32'sd9, -32'sd1
	};
	string dir_text [N_DIRECTED] = '{
		"0.", "0.00", "0.000000000", "0e7", "500.", "0.005", "1.00", "123.45",
		"-0.0012345", "1000000.", "1e7", "0.000000001", "1e-10", "-0.000000001", "-1.",
		"0.123456789", "1.234567890", "9223372036854775807.", "-9223372036854775808.",
		"9223372036854775807e2147483647", "-9223372036854775808e-2147483648",
		"-7e-2147483647", "", "", ""
	};

	decimal_mantissa_exponent_to_text_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mantissa (mantissa),
		.exponent (exponent),
		.empty    (empty),
		.pop      (pop),
		.out_char (out_char),
		.last     (last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicts the characters of one number and appends them to the expected text
	function automatic void format_number(input logic [MANT_IN_W-1:0] m_in,
			input logic [EXP_W-1:0] e_in);
		logic [MANTISSA_BITS-1:0] m_bits;
		logic [MANTISSA_BITS-1:0] mag;
		logic                     neg;
		logic                     eneg;
		logic [EXP_W-1:0]         emag;
		logic [63:0]              v;
		int                       ex;
		int                       intdig;
		int                       k;
		int                       z;
		logic [CHAR_W-1:0]        mdig[$];
		logic [CHAR_W-1:0]        edig[$];
		logic [CHAR_W-1:0]        txt[$];
		m_bits = m_in[MANTISSA_BITS-1:0];
		neg = m_bits[MANTISSA_BITS-1];
		mag = neg ? -m_bits : m_bits;
		eneg = e_in[EXP_W-1];
		emag = eneg ? -e_in : e_in;
		ex = int'($signed(e_in));

		// mantissa magnitude digits, most significant first
		v = 64'(mag);
		do begin
			mdig.push_front(CHAR_W'(CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);

		if (ex <= FIX_EXP_HIGH && ex >= FIX_EXP_LOW) begin
			// fixed notation
			intdig = (ex >= 0) ? mdig.size() : mdig.size() + ex;
			if (intdig < 0)
				intdig = 0;
			if (neg)
				txt.push_back(CH_MINUS);
			for (k = 0; k < intdig; k++)
				txt.push_back(mdig[k]);
			for (z = ex; z > 0; z--)
				txt.push_back(CH_ZERO);
			if (mdig.size() <= -ex)
				txt.push_back(CH_ZERO);
			txt.push_back(CH_POINT);
			for (z = -ex - mdig.size(); z > 0; z--)
				txt.push_back(CH_ZERO);
			for (k = intdig; k < mdig.size(); k++)
				txt.push_back(mdig[k]);
		end else begin
			// exponent notation
			v = 64'(emag);
			do begin
				edig.push_front(CHAR_W'(CH_ZERO + v % 10));
				v = v / 10;
			end while (v != 0);
			if (neg)
				txt.push_back(CH_MINUS);
			foreach (mdig[k])
				txt.push_back(mdig[k]);
			txt.push_back(CH_E);
			if (eneg)
				txt.push_back(CH_MINUS);
			foreach (edig[k])
				txt.push_back(edig[k]);
		end

		while (txt.size() > MAX_TEXT)
			void'(txt.pop_back());
		foreach (txt[k])
			expected_chars.push_back(text_char_t'{ch: txt[k], last: (k == txt.size() - 1)});
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin : monitor
		int         k;
		text_char_t want;
		if (arst_n) begin
			// input transaction
			if (push && !full) begin
				accepted_count++;
				if (exponent <= FIX_EXP_HIGH && exponent >= FIX_EXP_LOW)
					fixed_count++;
				else
					sci_count++;
				if (drive_text != "") begin
					for (k = 0; k < drive_text.len(); k++)
						expected_chars.push_back(text_char_t'{ch: CHAR_W'(drive_text[k]),
							last: (k == drive_text.len() - 1)});
				end else begin
					format_number(mantissa, exponent);
				end
			end
			if (push && full)
				stall_cycles++;

			// result transaction
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("%0t: unexpected character, expected none, actual %h last %b",
							$time, out_char, last);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					checked_chars++;
					if (out_char !== want.ch) begin
						if (error_count < MAX_REPORTS)
							$display("%0t: out_char mismatch, expected %h (%c), actual %h (%c)",
								$time, want.ch, want.ch, out_char, out_char);
						error_count++;
					end
					if (last !== want.last) begin
						if (error_count < MAX_REPORTS)
							$display("%0t: last mismatch, expected %b, actual %b",
								$time, want.last, last);
						error_count++;
					end
				end
			end
		end
	end

	// receiver: stretches of different pop patterns, plus one long hold-off
	initial begin : receiver
		int mode;
		int len;
		int phase;
		phase = 0;
		@(posedge arst_n);
		forever begin
			if (!held_off && accepted_count >= HOLD_AT) begin
				held_off = 1'b1;
				@(negedge clk);
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 300);
			repeat (len) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= (phase % 3 != 0);
				endcase
			end
		end
	end

	// sender, reset and end of run
	initial begin : sender
		logic [MANT_IN_W-1:0] nm;
		logic [EXP_W-1:0]     ne;
		logic [MANT_IN_W-1:0] p;
		string                nt;
		int                   idx;
		int                   gap;
		int                   burst_left;
		int                   r;
		burst_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (idx = 0; idx < N_DIRECTED + N_RANDOM; idx++) begin
			if (idx < N_DIRECTED) begin
				nm = dir_mant[idx];
				ne = dir_expo[idx];
				nt = dir_text[idx];
			end else begin
				nt = "";
				// mantissa: full range, short magnitudes, powers of ten, extremes
				case ($urandom_range(0, 9))
					0, 1: nm = {$urandom, $urandom};
					2, 3: begin
						nm = {$urandom, $urandom} >> $urandom_range(0, 63);
						if ($urandom_range(0, 1))
							nm = -nm;
					end
					4: nm = 64'(signed'($urandom_range(0, 1998)) - 999);
					5: begin
						p = 1;
						repeat ($urandom_range(0, 18)) p = p * 10;
						if ($urandom_range(0, 1))
							p = p - 1;
						nm = $urandom_range(0, 1) ? -p : p;
					end
					6: case ($urandom_range(0, 4))
						0: nm = 64'h8000_0000_0000_0000;
						1: nm = 64'h7FFF_FFFF_FFFF_FFFF;
						2: nm = '0;
						3: nm = '1;
						default: nm = 64'd1;
					endcase
					default: begin
						nm = {$urandom, $urandom} >> $urandom_range(40, 63);
						if ($urandom_range(0, 1))
							nm = -nm;
					end
				endcase
				// exponent: mostly the fixed window, its edges, and the full range
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: ne = 32'(signed'($urandom_range(0, 15)) + FIX_EXP_LOW);
					6: ne = 32'(signed'($urandom_range(0, 19)) - 11);
					7: ne = $urandom;
					8: case ($urandom_range(0, 3))
						0: ne = 32'h8000_0000;
						1: ne = 32'h7FFF_FFFF;
						2: ne = $urandom_range(7, 100);
						default: ne = -32'($urandom_range(10, 100));
					endcase
					default: begin
						ne = $urandom >> $urandom_range(0, 31);
						if ($urandom_range(0, 1))
							ne = -ne;
					end
				endcase
			end

			// idle between bursts; once, wait for the block to drain completely
			if (idx == PAUSE_AT) begin
				@(negedge clk);
				push <= 1'b0;
				while (expected_chars.size() != 0) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end else if (burst_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					gap = 0;
				else if (r < 85)
					gap = $urandom_range(1, 6);
				else if (r < 97)
					gap = $urandom_range(7, 40);
				else
					gap = $urandom_range(41, 150);
				if (idx >= QUIET_FROM && idx < QUIET_TO)
					gap = 0;
				if (gap != 0) begin
					@(negedge clk);
					push <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;

			// offer the transaction and hold it until accepted
			@(negedge clk);
			push <= 1'b1;
			mantissa <= nm;
			exponent <= ne;
			drive_text = nt;
			@(posedge clk);
			while (full) @(posedge clk);
		end
		@(negedge clk);
		push <= 1'b0;

		// drain, then allow for any stray output
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d numbers (%0d fixed, %0d exponent form), %0d characters checked",
			accepted_count, fixed_count, sci_count, checked_chars);
		$display("input held off by a full queue on %0d cycles", stall_cycles);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#TIMEOUT_NS;
		$display("timeout with %0d characters outstanding", expected_chars.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
